FILE: rtl/sorted_priority_queue_core_macros.svh
// assertion macros for the sorted priority queue core checker
// no dependencies; included by the checker file
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spq check failed");

// next-cycle implication, sampled on clk, off during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spq check failed");

`endif

FILE: rtl/spq_pkg.sv
// shared widths, codes and control structs for the sorted priority queue
// no dependencies
`default_nettype none

package spq_pkg;

    localparam int KEY_W   = 31;
    localparam int TAG_W   = 16;
    localparam int FAULT_W = 2;
    localparam int OCC_W   = 5;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_FULL  = 2'd2;

    typedef struct packed {
        logic               exec;
        logic               insert;
        logic               remove;
        logic [FAULT_W-1:0] fault;
    } spq_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } spq_status_t;

endpackage

`default_nettype wire

FILE: rtl/spq_ctrl.sv
// controller: handshake sequencing and operation decode
// depends on spq_pkg
`default_nettype none

module spq_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 action,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire spq_pkg::spq_status_t status,
    output spq_pkg::spq_cmd_t         cmd
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_HOLD = 1'b1;

    logic state_reg;
    logic state_next;
    logic exec;

    // a held word that is being taken frees the result register this cycle
    assign in_ready  = (state_reg == ST_IDLE) || out_ready;
    assign out_valid = (state_reg == ST_HOLD);
    assign exec      = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        cmd.exec   = exec;
        if (action == ACT_INSERT)
        begin
            if (status.full)
                cmd.fault = FAULT_FULL;
            else
                cmd.insert = exec;
        end
        else
        begin
            if (status.empty)
                cmd.fault = FAULT_EMPTY;
            else
                cmd.remove = exec;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (exec)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (exec)
                    state_next = ST_HOLD;
                else if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

FILE: rtl/spq_datapath.sv
// datapath: row of sorted entry cells, min tracking and result register
// depends on spq_pkg
`default_nettype none

module spq_datapath
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire spq_pkg::spq_cmd_t           cmd,
    output spq_pkg::spq_status_t             status,
    input  wire logic [spq_pkg::KEY_W-1:0]   key_in,
    input  wire logic [spq_pkg::TAG_W-1:0]   tag_in,
    output logic                             removed_valid,
    output logic [spq_pkg::KEY_W-1:0]        removed_key,
    output logic [spq_pkg::TAG_W-1:0]        removed_tag,
    output logic [spq_pkg::FAULT_W-1:0]      fault,
    output logic [spq_pkg::KEY_W-1:0]        min_key,
    output logic [spq_pkg::TAG_W-1:0]        min_tag,
    output logic [spq_pkg::OCC_W-1:0]        occupancy
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [KEY_W-1:0]   key_reg  [QUEUE_DEPTH];
    logic [TAG_W-1:0]   tag_reg  [QUEUE_DEPTH];
    logic [KEY_W-1:0]   key_next [QUEUE_DEPTH];
    logic [TAG_W-1:0]   tag_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] gt;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [KEY_W-1:0]   min_key_reg;
    logic [KEY_W-1:0]   min_key_next;
    logic [TAG_W-1:0]   min_tag_reg;
    logic [TAG_W-1:0]   min_tag_next;

    logic               removed_valid_reg;
    logic [KEY_W-1:0]   removed_key_reg;
    logic [TAG_W-1:0]   removed_tag_reg;
    logic [FAULT_W-1:0] fault_reg;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));

    // per-cell compare: stored entry stays ahead of the new one
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            gt[i] = (CNT_W'(i) < count_reg) && (key_reg[i] > key_in);
    end

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            key_next[i] = key_reg[i];
            tag_next[i] = tag_reg[i];
            if (cmd.insert && !gt[i])
            begin
                if (i == 0 || gt[(i == 0) ? 0 : i - 1])
                begin
                    key_next[i] = key_in;
                    tag_next[i] = tag_in;
                end
                else
                begin
                    key_next[i] = key_reg[(i == 0) ? 0 : i - 1];
                    tag_next[i] = tag_reg[(i == 0) ? 0 : i - 1];
                end
            end
            else if (cmd.remove && i < QUEUE_DEPTH - 1)
            begin
                key_next[i] = key_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
                tag_next[i] = tag_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    // min is the frontmost entry of the tail group of equal keys
    always_comb
    begin
        count_next   = count_reg;
        min_key_next = min_key_reg;
        min_tag_next = min_tag_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
            if (status.empty || key_in <= min_key_reg)
            begin
                min_key_next = key_in;
                min_tag_next = tag_in;
            end
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                min_key_next = '0;
                min_tag_next = '0;
            end
            else if (key_reg[0] == min_key_reg)
            begin
                min_tag_next = tag_reg[1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            key_reg[i] <= key_next[i];
            tag_reg[i] <= tag_next[i];
        end
        if (cmd.exec)
        begin
            removed_valid_reg <= cmd.remove;
            removed_key_reg   <= cmd.remove ? key_reg[0] : '0;
            removed_tag_reg   <= cmd.remove ? tag_reg[0] : '0;
            fault_reg         <= cmd.fault;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            min_key_reg <= '0;
            min_tag_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            min_key_reg <= min_key_next;
            min_tag_reg <= min_tag_next;
        end
    end

    assign occ_wide      = {{OCC_W{1'b0}}, count_reg};
    assign removed_valid = removed_valid_reg;
    assign removed_key   = removed_key_reg;
    assign removed_tag   = removed_tag_reg;
    assign fault         = fault_reg;
    assign min_key       = min_key_reg;
    assign min_tag       = min_tag_reg;
    assign occupancy     = occ_wide[OCC_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/sorted_priority_queue_core.sv
// Sorted priority queue core.
// Input channel (in_valid/in_ready) carries one word: action, key_in, tag_in.
// action insert places the entry behind every stored entry with a larger key,
// so the newest of equal keys sits first; action remove pops the front
// (largest) entry. Output channel (out_valid/out_ready) returns one word per
// input word: removed entry, fault code, minimum entry and occupancy.
// The result is registered at the edge that accepts the input word, and the
// output is driven from that register.
// Throughput: one word per cycle while the output is not stalled; all cells
// compare against the new key in parallel and shift in the same edge, and the
// result register is the only holding point between the channels.
// Stall: while out_valid is high and out_ready low, in_ready stays low and
// the result holds; a word taken in the same cycle frees room for the next.
// Reset: occupancy clears to zero and the output register empties; entry
// cells are not cleared, only entries below the occupancy are ever read.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
`default_nettype none

module sorted_priority_queue_core
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [spq_pkg::KEY_W-1:0]   key_in,
    input  wire logic [spq_pkg::TAG_W-1:0]   tag_in,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             removed_valid,
    output logic [spq_pkg::KEY_W-1:0]        removed_key,
    output logic [spq_pkg::TAG_W-1:0]        removed_tag,
    output logic [spq_pkg::FAULT_W-1:0]      fault,
    output logic [spq_pkg::KEY_W-1:0]        min_key,
    output logic [spq_pkg::TAG_W-1:0]        min_tag,
    output logic [spq_pkg::OCC_W-1:0]        occupancy
);
    import spq_pkg::*;

    spq_cmd_t    cmd;
    spq_status_t status;

    spq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .key_in        (key_in),
        .tag_in        (tag_in),
        .removed_valid (removed_valid),
        .removed_key   (removed_key),
        .removed_tag   (removed_tag),
        .fault         (fault),
        .min_key       (min_key),
        .min_tag       (min_tag),
        .occupancy     (occupancy)
    );

endmodule

`default_nettype wire

FILE: rtl/spq_checker.sv
// port-level checker for the sorted priority queue core, with its bind
// depends on spq_pkg and sorted_priority_queue_core_macros.svh
`default_nettype none

`include "sorted_priority_queue_core_macros.svh"

module spq_checker
(
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic                        removed_valid,
    input wire logic [spq_pkg::KEY_W-1:0]   removed_key,
    input wire logic [spq_pkg::TAG_W-1:0]   removed_tag,
    input wire logic [spq_pkg::FAULT_W-1:0] fault,
    input wire logic [spq_pkg::KEY_W-1:0]   min_key,
    input wire logic [spq_pkg::TAG_W-1:0]   min_tag,
    input wire logic [spq_pkg::OCC_W-1:0]   occupancy
);
    import spq_pkg::*;

    // a stalled result word holds
    `SPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(removed_key) && $stable(removed_tag) && $stable(fault)
        && $stable(min_key) && $stable(occupancy))

    // an accepted word always produces a result next cycle
    `SPQ_ASSERT_NEXT(a_accept_result, in_valid && in_ready, out_valid)

    // a popped entry never comes with a fault
    `SPQ_ASSERT_NOW(a_pop_no_fault, out_valid && removed_valid, fault == FAULT_NONE)

    // empty-queue remove leaves nothing stored and reports a zero minimum
    `SPQ_ASSERT_NOW(a_empty_fault, out_valid && fault == FAULT_EMPTY,
        !removed_valid && occupancy == '0 && min_key == '0 && min_tag == '0)

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);

`default_nettype wire

FILE: verif/tb_sorted_priority_queue_core.sv
`timescale 1ns / 100ps
// self-checking testbench for sorted_priority_queue_core: keeps a shadow sorted list,
// predicts one status word per accepted op and compares every returned word field by field
// depends on spq_pkg and the sorted_priority_queue_core rtl

module tb_sorted_priority_queue_core;

    import spq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 40;

    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};

    typedef struct packed {
        logic               removed_valid;
        logic [KEY_W-1:0]   removed_key;
        logic [TAG_W-1:0]   removed_tag;
        logic [FAULT_W-1:0] fault;
        logic [KEY_W-1:0]   min_key;
        logic [TAG_W-1:0]   min_tag;
        logic [OCC_W-1:0]   occupancy;
    } queue_status_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               action = ACT_INSERT;
    logic [KEY_W-1:0]   key_in = '0;
    logic [TAG_W-1:0]   tag_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               removed_valid;
    logic [KEY_W-1:0]   removed_key;
    logic [TAG_W-1:0]   removed_tag;
    logic [FAULT_W-1:0] fault;
    logic [KEY_W-1:0]   min_key;
    logic [TAG_W-1:0]   min_tag;
    logic [OCC_W-1:0]   occupancy;

    // shadow copy of the sorted list, front at index 0
    logic [KEY_W-1:0] shadow_keys [DEPTH];
    logic [TAG_W-1:0] shadow_tags [DEPTH];
    int               shadow_count = 0;

    queue_status_t status_due [$];

    int gap_pct       = 0;
    int stall_pct     = 0;
    int hold_left     = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int n_insert      = 0;
    int n_full_drop   = 0;
    int n_remove      = 0;
    int n_empty_pop   = 0;
    int peak_fill     = 0;

    sorted_priority_queue_core #(
        .QUEUE_DEPTH (DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .key_in        (key_in),
        .tag_in        (tag_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .removed_valid (removed_valid),
        .removed_key   (removed_key),
        .removed_tag   (removed_tag),
        .fault         (fault),
        .min_key       (min_key),
        .min_tag       (min_tag),
        .occupancy     (occupancy)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // applies one op to the shadow list and returns the status word it produces
    function automatic queue_status_t sorted_op_status(input logic act,
                                                       input logic [KEY_W-1:0] key,
                                                       input logic [TAG_W-1:0] tag);
        queue_status_t st;
        int            pos;
        st = '0;
        if (act == ACT_INSERT)
        begin
            if (shadow_count >= DEPTH)
                st.fault = FAULT_FULL;
            else
            begin
                // new entry goes behind every strictly larger key
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] > key)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_tags[i] = shadow_tags[i-1];
                end
                shadow_keys[pos] = key;
                shadow_tags[pos] = tag;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            st.fault = FAULT_EMPTY;
        else
        begin
            st.removed_valid = 1'b1;
            st.removed_key   = shadow_keys[0];
            st.removed_tag   = shadow_tags[0];
            for (int i = 1; i < shadow_count; i++)
            begin
                shadow_keys[i-1] = shadow_keys[i];
                shadow_tags[i-1] = shadow_tags[i];
            end
            shadow_count--;
        end
        // frontmost of the smallest keys wins, i.e. the newest among equals
        if (shadow_count > 0)
        begin
            st.min_key = shadow_keys[0];
            st.min_tag = shadow_tags[0];
            for (int i = 1; i < shadow_count; i++)
            begin
                if (shadow_keys[i] < st.min_key)
                begin
                    st.min_key = shadow_keys[i];
                    st.min_tag = shadow_tags[i];
                end
            end
        end
        st.occupancy = OCC_W'(shadow_count);
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // result words are checked before the word accepted at the same edge is predicted
    always @(posedge clk)
    begin : word_monitor
        queue_status_t got;
        queue_status_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{removed_valid, removed_key, removed_tag, fault,
                        min_key, min_tag, occupancy};
                words_checked++;
                if (status_due.size() == 0)
                    report_mismatch("unexpected word", 32'(got.occupancy), 32'h0);
                else
                begin
                    want = status_due[0];
                    status_due.delete(0);
                    if (got.removed_valid !== want.removed_valid)
                        report_mismatch("removed_valid", 32'(got.removed_valid),
                                        32'(want.removed_valid));
                    if (got.removed_key !== want.removed_key)
                        report_mismatch("removed_key", 32'(got.removed_key),
                                        32'(want.removed_key));
                    if (got.removed_tag !== want.removed_tag)
                        report_mismatch("removed_tag", 32'(got.removed_tag),
                                        32'(want.removed_tag));
                    if (got.fault !== want.fault)
                        report_mismatch("fault", 32'(got.fault), 32'(want.fault));
                    if (got.min_key !== want.min_key)
                        report_mismatch("min_key", 32'(got.min_key), 32'(want.min_key));
                    if (got.min_tag !== want.min_tag)
                        report_mismatch("min_tag", 32'(got.min_tag), 32'(want.min_tag));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 32'(got.occupancy),
                                        32'(want.occupancy));
                end
            end
            if (in_valid && in_ready)
            begin
                want = sorted_op_status(action, key_in, tag_in);
                status_due.insert(status_due.size(), want);
                if (action == ACT_INSERT)
                begin
                    n_insert++;
                    if (want.fault == FAULT_FULL)
                        n_full_drop++;
                end
                else
                begin
                    n_remove++;
                    if (want.fault == FAULT_EMPTY)
                        n_empty_pop++;
                end
                if (shadow_count > peak_fill)
                    peak_fill = shadow_count;
            end
        end
    end

    // output side: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words sent, %0d checked",
                     cycle_count, words_sent, words_checked);
            $display("FAIL sorted_priority_queue_core");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] tag);
        in_valid <= 1'b1;
        action   <= act;
        key_in   <= key;
        tag_in   <= tag;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_checked < words_sent)
            @(posedge clk);
    endtask

    // tiny keys often enough that duplicates are common, plus the extremes and full-range keys
    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return KEY_MAX;
            2, 3, 4: return KEY_W'($urandom_range(7));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    task automatic send_random_burst(input int n_words);
        int   insert_pct;
        logic act;
        insert_pct = 50;
        for (int i = 0; i < n_words; i++)
        begin
            // biased stretches drive the list to full and back to empty
            if (i % 32 == 0)
            begin
                case ($urandom_range(2))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    default: insert_pct = 85;
                endcase
            end
            act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
            send_word(act, pick_key(), TAG_W'($urandom_range(TAG_MAX)));
        end
    endtask

    task automatic test_directed_edges();
        gap_pct = 0;
        stall_pct <= 0;
        send_word(ACT_REMOVE, KEY_MAX, TAG_MAX);
        send_word(ACT_INSERT, KEY_MAX, TAG_MAX);
        send_word(ACT_INSERT, '0, 16'h1234);
        // second zero key sits in front of the first and becomes the reported minimum
        send_word(ACT_INSERT, '0, 16'habcd);
        send_word(ACT_INSERT, 31'h2aaa_aaaa, 16'h5555);
        for (int i = 0; i < 11; i++)
            send_word(ACT_INSERT, 31'h5555_5555 ^ KEY_W'(i), 16'h00aa + TAG_W'(i));
        send_word(ACT_INSERT, 31'h1, 16'h0001);
        // list is full now, this one is dropped
        send_word(ACT_INSERT, 31'h7, 16'h7777);
        send_word(ACT_REMOVE, '0, '0);
        send_word(ACT_REMOVE, '0, '0);
        send_word(ACT_INSERT, KEY_MAX, 16'h0000);
        send_word(ACT_REMOVE, '0, '0);
        wait_drain();
    endtask

    task automatic test_random_mix(input int n_words, input int sender_gap,
                                   input int sink_stall);
        gap_pct = sender_gap;
        stall_pct <= sink_stall;
        send_random_burst(n_words);
        wait_drain();
    endtask

    task automatic test_output_hold();
        gap_pct = 0;
        stall_pct <= 0;
        // output held off long enough that the input stalls behind it
        hold_left <= 400;
        send_random_burst(40);
        wait_drain();
    endtask

    task automatic test_pause_until_empty();
        gap_pct = 10;
        stall_pct <= 20;
        send_random_burst(25);
        wait_drain();
        send_random_burst(25);
        wait_drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_random_mix(220, 0, 0);
        test_random_mix(200, 80, 0);
        test_random_mix(200, 0, 80);
        test_random_mix(200, 28, 28);
        test_output_hold();
        test_pause_until_empty();

        repeat (4) @(posedge clk);
        while (status_due.size() != 0)
        begin
            report_mismatch("missing word", 32'(status_due[0].occupancy), 32'h0);
            status_due.delete(0);
        end

        $display("covered %0d inserts (%0d dropped on full) and %0d removes (%0d on empty)",
                 n_insert, n_full_drop, n_remove, n_empty_pop);
        $display("peak fill %0d of %0d, %0d words checked, %0d mismatches",
                 peak_fill, DEPTH, words_checked, error_count);
        if (error_count == 0)
            $display("PASS sorted_priority_queue_core");
        else
            $display("FAIL sorted_priority_queue_core");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/sorted_priority_queue_core.sv
rtl/spq_checker.sv
verif/tb_sorted_priority_queue_core.sv
